// ===== design/b64lw_pkg.sv =====
// Package: shared job type, character constants and alphabet lookup for the encoder.
`timescale 1ns / 1ps
`default_nettype none
package b64lw_pkg;

    localparam logic [7:0] CHAR_PAD     = 8'h3d;  // '='
    localparam logic [7:0] CHAR_NEWLINE = 8'h0a;
    localparam logic [5:0] GROUPS_RESET = 6'd18;

    // Number of '=' in a group
    localparam logic [1:0] PAD_NONE = 2'd0;
    localparam logic [1:0] PAD_ONE  = 2'd1;
    localparam logic [1:0] PAD_TWO  = 2'd2;

    // One group of four characters, with an optional trailing newline
    typedef struct packed {
        logic [23:0] word;
        logic [1:0]  pad_cnt;
        logic        has_nl;
        logic        is_end;
    } t_job;

    function automatic logic [7:0] b64_sym(input logic [5:0] v);
        logic [7:0] v8;
        v8 = {2'b00, v};
        if (v < 6'd26)
            return 8'h41 + v8;
        else if (v < 6'd52)
            return 8'h61 + v8 - 8'd26;
        else if (v < 6'd62)
            return 8'h30 + v8 - 8'd52;
        else if (v == 6'd62)
            return 8'h2b;
        else
            return 8'h2f;
    endfunction

endpackage
`default_nettype wire

// ===== design/b64lw_in_if.sv =====
// Interface: byte input channel with valid/ready handshake.
`timescale 1ns / 1ps
`default_nettype none
interface b64lw_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       is_final;

    modport source (output valid, output data_byte, output is_final, input ready);
    modport sink   (input valid, input data_byte, input is_final, output ready);
endinterface
`default_nettype wire

// ===== design/b64lw_out_if.sv =====
// Interface: character output channel with valid/ready handshake.
`timescale 1ns / 1ps
`default_nettype none
interface b64lw_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_char;
    logic       run_end;
    logic       stream_end;

    modport source (output valid, output out_char, output run_end, output stream_end,
                    input ready);
    modport sink   (input valid, input out_char, input run_end, input stream_end,
                    output ready);
endinterface
`default_nettype wire

// ===== design/b64lw_front.sv =====
// Front end: collects bytes into groups, tracks line position, issues group jobs.
`timescale 1ns / 1ps
`default_nettype none
module b64lw_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_cfg_wr_en,
    input  wire logic [5:0]    i_cfg_wr_data,
    b64lw_in_if.sink           i_in,
    input  wire logic          i_q_ready,
    output logic               o_push,
    output b64lw_pkg::t_job    o_job
);
    import b64lw_pkg::*;

    logic [5:0]  r_groups_per_line;
    logic [15:0] r_pend_bytes, n_pend_bytes;
    logic [1:0]  r_pend_cnt, n_pend_cnt;
    logic [5:0]  r_line_cnt, n_line_cnt;
    logic        accept;
    logic [5:0]  line_inc;
    logic        wrap;

    assign i_in.ready = i_q_ready;
    assign accept     = i_in.valid && i_q_ready;
    assign line_inc   = r_line_cnt + 6'd1;
    assign wrap       = (line_inc == r_groups_per_line);

    always_comb begin
        n_pend_bytes = r_pend_bytes;
        n_pend_cnt   = r_pend_cnt;
        n_line_cnt   = r_line_cnt;
        o_push       = 1'b0;
        o_job        = '0;
        if (accept) begin
            if (r_pend_cnt == 2'd2) begin
                // Full group; a final byte forces the closing newline
                o_push       = 1'b1;
                o_job.word   = {r_pend_bytes, i_in.data_byte};
                o_job.pad_cnt = PAD_NONE;
                o_job.has_nl = wrap || i_in.is_final;
                o_job.is_end = i_in.is_final;
                n_pend_cnt   = 2'd0;
                n_line_cnt   = (wrap || i_in.is_final) ? 6'd0 : line_inc;
            end else if (i_in.is_final) begin
                o_push       = 1'b1;
                o_job.has_nl = 1'b1;
                o_job.is_end = 1'b1;
                if (r_pend_cnt == 2'd0) begin
                    o_job.word    = {i_in.data_byte, 16'h0000};
                    o_job.pad_cnt = PAD_TWO;
                end else begin
                    o_job.word    = {r_pend_bytes[7:0], i_in.data_byte, 8'h00};
                    o_job.pad_cnt = PAD_ONE;
                end
                n_pend_cnt = 2'd0;
                n_line_cnt = 6'd0;
            end else begin
                n_pend_bytes = {r_pend_bytes[7:0], i_in.data_byte};
                n_pend_cnt   = r_pend_cnt + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_groups_per_line <= GROUPS_RESET;
            r_pend_cnt        <= 2'd0;
            r_line_cnt        <= 6'd0;
        end else begin
            if (i_cfg_wr_en)
                r_groups_per_line <= i_cfg_wr_data;
            r_pend_cnt <= n_pend_cnt;
            r_line_cnt <= n_line_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend_bytes <= n_pend_bytes;
    end

    a_pend_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend_cnt != 2'd3)
        else $error("pending byte count out of range");

    a_final_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_in.is_final |=> r_pend_cnt == 2'd0 && r_line_cnt == 6'd0)
        else $error("final byte did not clear group state");

endmodule
`default_nettype wire

// ===== design/b64lw_queue.sv =====
// Job queue: small register FIFO between front end and character emitter.
`timescale 1ns / 1ps
`default_nettype none
module b64lw_queue #(
    parameter int DEPTH = 4  // 2 or more
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  b64lw_pkg::t_job    i_job,
    output logic               o_ready,
    output logic               o_valid,
    output b64lw_pkg::t_job    o_job,
    input  wire logic          i_pop
);
    import b64lw_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_job             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push, do_pop;

    assign o_ready = (r_count != CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_job   = r_mem[r_rd_ptr];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push)
                r_wr_ptr <= ptr_next(r_wr_ptr);
            if (do_pop)
                r_rd_ptr <= ptr_next(r_rd_ptr);
            if (do_push && !do_pop)
                r_count <= r_count + CNT_W'(1);
            else if (do_pop && !do_push)
                r_count <= r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push)
            r_mem[r_wr_ptr] <= i_job;
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("queue count exceeds depth");

endmodule
`default_nettype wire

// ===== design/b64lw_back.sv =====
// Back end: walks each queued group to output reg one char per cycle unless stalled.
`timescale 1ns / 1ps
`default_nettype none
module b64lw_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_q_valid,
    input  b64lw_pkg::t_job    i_job,
    output logic               o_pop,
    b64lw_out_if.source        o_out
);
    import b64lw_pkg::*;

    localparam logic [2:0] IDX_SYM0 = 3'd0;
    localparam logic [2:0] IDX_SYM1 = 3'd1;
    localparam logic [2:0] IDX_SYM2 = 3'd2;
    localparam logic [2:0] IDX_SYM3 = 3'd3;
    localparam logic [2:0] IDX_NL   = 3'd4;

    logic [2:0] r_idx;
    logic       r_out_valid;
    logic [7:0] r_out_char;
    logic       r_run_end, r_stream_end;
    logic       load;
    logic       last;
    logic [7:0] ch;

    assign load  = i_q_valid && (!r_out_valid || o_out.ready);
    assign last  = (r_idx == IDX_NL) || (r_idx == IDX_SYM3 && !i_job.has_nl);
    assign o_pop = load && last;

    always_comb begin
        case (r_idx)
            IDX_SYM0: ch = b64_sym(i_job.word[23:18]);
            IDX_SYM1: ch = b64_sym(i_job.word[17:12]);
            IDX_SYM2: ch = (i_job.pad_cnt == PAD_TWO) ? CHAR_PAD : b64_sym(i_job.word[11:6]);
            IDX_SYM3: ch = (i_job.pad_cnt != PAD_NONE) ? CHAR_PAD : b64_sym(i_job.word[5:0]);
            default:  ch = CHAR_NEWLINE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= IDX_SYM0;
            r_out_valid <= 1'b0;
        end else begin
            if (load)
                r_idx <= last ? IDX_SYM0 : r_idx + 3'd1;
            if (load)
                r_out_valid <= 1'b1;
            else if (o_out.ready)
                r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out_char   <= ch;
            r_run_end    <= last;
            r_stream_end <= (r_idx == IDX_NL) && i_job.is_end;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.out_char   = r_out_char;
    assign o_out.run_end    = r_run_end;
    assign o_out.stream_end = r_stream_end;

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx <= IDX_NL)
        else $error("character index out of range");

    a_end_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_stream_end |-> r_run_end && r_out_char == CHAR_NEWLINE)
        else $error("stream end not on a closing newline");

endmodule
`default_nettype wire

// ===== design/base64_encoder_line_wrap_core.sv =====
// Top level: streaming base64 encoder with line wrapping.
// Bytes enter on i_in, one per transaction, is_final on the last byte of a stream; characters
// leave on o_out one per transaction, with run_end on the last character caused by a byte and
// stream_end on the closing newline. The front end takes a byte every cycle while the job
// queue (QUEUE_DEPTH groups) has room; the back end emits one character per cycle while o_out
// is ready, four per group plus a newline when the group carries one, so sustained input is
// limited by the single-character output register. The first character of a group reaches
// o_out through the job queue and then the output register.
// Write groups_per_line only while idle.
`timescale 1ns / 1ps
`default_nettype none
module base64_encoder_line_wrap_core #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_wr_en,
    input  wire logic [5:0] i_cfg_wr_data,
    b64lw_in_if.sink        i_in,
    b64lw_out_if.source     o_out
);
    import b64lw_pkg::*;

    logic q_ready, q_valid, push, pop;
    t_job front_job, head_job;

    b64lw_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in          (i_in),
        .i_q_ready     (q_ready),
        .o_push        (push),
        .o_job         (front_job)
    );

    b64lw_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (front_job),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .o_job   (head_job),
        .i_pop   (pop)
    );

    b64lw_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_job     (head_job),
        .o_pop     (pop),
        .o_out     (o_out)
    );

endmodule
`default_nettype wire

// ===== test/base64_encoder_line_wrap_core_tb.sv =====
// Testbench: random and directed byte streams through the line-wrapping base64 encoder.
`timescale 1ns / 1ps
module base64_encoder_line_wrap_core_tb;
    import b64lw_pkg::*;

    localparam int IDLE_LIMIT  = 3000;
    localparam int SETTLE_CYC  = 10;
    localparam int MAX_REPORTS = 10;
    localparam logic [511:0] B64_ALPHABET =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

    typedef struct packed {
        logic [7:0] data;
        logic       fin;
    } t_byte_item;

    typedef struct packed {
        logic [7:0] ch;
        logic       run_end;
        logic       stream_end;
    } t_char_rec;

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_cfg_wr_en;
    logic [5:0] i_cfg_wr_data;

    b64lw_in_if  in_if();
    b64lw_out_if out_if();

    base64_encoder_line_wrap_core uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in          (in_if),
        .o_out         (out_if)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    t_byte_item src_bytes[$];
    t_char_rec  exp_chars[$];
    int         mismatch_cnt = 0;

    // Encoder state mirrored by the predictor
    logic [5:0]  groups_per_line = GROUPS_RESET;
    logic [15:0] hold_bytes      = '0;
    logic [1:0]  hold_cnt        = '0;
    logic [5:0]  line_groups     = '0;
    t_char_rec   run_buf [0:4];
    int          run_len;

    function automatic logic [7:0] b64_char(input logic [5:0] idx);
        return B64_ALPHABET[8*(63 - int'(idx)) +: 8];
    endfunction

    function automatic void stage_char(input logic [7:0] ch, input logic last_nl);
        run_buf[run_len] = '{ch: ch, run_end: 1'b0, stream_end: last_nl};
        run_len++;
    endfunction

    // Work out the characters one accepted byte produces and queue them
    function automatic void predict_chars(input logic [7:0] b, input logic fin);
        logic [23:0] word;
        logic        nl_last;
        t_char_rec   rec;
        nl_last = 1'b0;
        run_len = 0;
        if (hold_cnt == 2'd2) begin
            word = {hold_bytes, b};
            for (int k = 0; k < 4; k++)
                stage_char(b64_char(word[23 - 6*k -: 6]), 1'b0);
            hold_bytes  = '0;
            hold_cnt    = '0;
            line_groups = line_groups + 6'd1;
            if (line_groups == groups_per_line) begin
                stage_char(CHAR_NEWLINE, fin);
                line_groups = '0;
                nl_last     = 1'b1;
            end
        end else begin
            hold_bytes = {hold_bytes[7:0], b};
            hold_cnt   = hold_cnt + 2'd1;
        end
        if (fin) begin
            if (hold_cnt != 2'd0) begin
                word = (hold_cnt == 2'd1) ? {hold_bytes[7:0], 16'h0000} : {hold_bytes, 8'h00};
                stage_char(b64_char(word[23:18]), 1'b0);
                stage_char(b64_char(word[17:12]), 1'b0);
                stage_char((hold_cnt == 2'd1) ? CHAR_PAD : b64_char(word[11:6]), 1'b0);
                stage_char(CHAR_PAD, 1'b0);
                nl_last = 1'b0;
            end
            if (!nl_last)
                stage_char(CHAR_NEWLINE, 1'b1);
            hold_bytes  = '0;
            hold_cnt    = '0;
            line_groups = '0;
        end
        for (int i = 0; i < run_len; i++) begin
            rec = run_buf[i];
            if (i == run_len - 1)
                rec.run_end = 1'b1;
            exp_chars.push_back(rec);
        end
    endfunction

    // Sender: bursts of random length separated by random gaps
    int burst_left = 0;
    int gap_left   = 0;
    logic byte_taken;
    logic char_taken;

    always @(posedge i_clk) begin : byte_driver
        t_byte_item item;
        if (!i_rst_n) begin
            in_if.valid     <= 1'b0;
            in_if.data_byte <= '0;
            in_if.is_final  <= 1'b0;
        end else begin
            if (in_if.valid && in_if.ready)
                predict_chars(in_if.data_byte, in_if.is_final);
            // hold the item until the transaction completes
            if (!(in_if.valid && !in_if.ready)) begin
                if (gap_left > 0) begin
                    gap_left--;
                    in_if.valid <= 1'b0;
                end else if (src_bytes.size() > 0) begin
                    item = src_bytes.pop_front();
                    in_if.valid     <= 1'b1;
                    in_if.data_byte <= item.data;
                    in_if.is_final  <= item.fin;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 30);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end else begin
                    in_if.valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: stall pattern switches between always ready, random and long stalls
    int stall_mode = 0;
    int mode_left  = 0;
    int stall_left = 0;

    task automatic log_mismatch(input logic have_exp, input t_char_rec want,
                                input t_char_rec got);
        mismatch_cnt++;
        if (mismatch_cnt <= MAX_REPORTS) begin
            if (have_exp)
                $display("[%0t] mismatch: expected %02h/%b/%b, got %02h/%b/%b",
                         $time, want.ch, want.run_end, want.stream_end,
                         got.ch, got.run_end, got.stream_end);
            else
                $display("[%0t] mismatch: unexpected char %02h run_end %b stream_end %b",
                         $time, got.ch, got.run_end, got.stream_end);
        end
    endtask

    always @(posedge i_clk) begin : char_monitor
        t_char_rec want;
        t_char_rec got;
        logic      rdy;
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else begin
            if (out_if.valid && out_if.ready) begin
                got = '{ch: out_if.out_char, run_end: out_if.run_end,
                        stream_end: out_if.stream_end};
                if (exp_chars.size() == 0) begin
                    log_mismatch(1'b0, got, got);
                end else begin
                    want = exp_chars.pop_front();
                    if (got.ch !== want.ch || got.run_end !== want.run_end ||
                        got.stream_end !== want.stream_end)
                        log_mismatch(1'b1, want, got);
                end
            end
            if (mode_left == 0) begin
                stall_mode = $urandom_range(0, 2);
                mode_left  = $urandom_range(40, 160);
            end else begin
                mode_left--;
            end
            case (stall_mode)
                0: rdy = 1'b1;
                1: rdy = ($urandom_range(0, 1) == 1);
                default: begin
                    if (stall_left > 0) begin
                        stall_left--;
                        rdy = 1'b0;
                    end else begin
                        rdy = 1'b1;
                        if ($urandom_range(0, 3) == 0)
                            stall_left = $urandom_range(1, 12);
                    end
                end
            endcase
            out_if.ready <= rdy;
        end
    end

    // Watchdog: end the run if no transaction moves for too long
    int idle_cycles = 0;

    always @(posedge i_clk) begin
        byte_taken = in_if.valid && in_if.ready;
        char_taken = out_if.valid && out_if.ready;
        if (!i_rst_n || byte_taken || char_taken) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("base64_encoder_line_wrap_core test failed");
                $finish;
            end
        end
    end

    task automatic push_byte(input logic [7:0] b, input logic fin);
        src_bytes.push_back('{data: b, fin: fin});
    endtask

    task automatic push_stream(input int len, input logic close);
        for (int i = 0; i < len; i++)
            push_byte(8'($urandom_range(0, 255)), close && (i == len - 1));
    endtask

    // Wait until every byte is taken and every character has come out
    task automatic drain();
        while (src_bytes.size() != 0 || in_if.valid || exp_chars.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    task automatic write_groups(input logic [5:0] v);
        @(posedge i_clk);
        i_cfg_wr_en     <= 1'b1;
        i_cfg_wr_data   <= v;
        groups_per_line  = v;
        @(posedge i_clk);
        i_cfg_wr_en     <= 1'b0;
    endtask

    initial begin : stimulus
        logic [5:0] phase_groups [0:4];
        int         phase_items;
        int         len;
        i_rst_n         = 1'b0;
        i_cfg_wr_en     = 1'b0;
        i_cfg_wr_data   = '0;
        in_if.valid     = 1'b0;
        in_if.data_byte = '0;
        in_if.is_final  = 1'b0;
        out_if.ready    = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset setting: single and double leftover bytes, full groups, extremes
        push_byte(8'hff, 1'b1);
        push_byte(8'h00, 1'b0);
        push_byte(8'hff, 1'b1);
        push_byte(8'hfb, 1'b0);
        push_byte(8'hef, 1'b0);
        push_byte(8'hbe, 1'b1);
        push_byte(8'hff, 1'b0);
        push_byte(8'hff, 1'b0);
        push_byte(8'hff, 1'b1);
        push_stream(3, 1'b0);
        push_byte(8'h00, 1'b1);
        drain();

        // One group per line: wrap newline closes the stream; padded group after a wrap
        write_groups(6'd1);
        push_byte(8'h01, 1'b0);
        push_byte(8'h02, 1'b0);
        push_byte(8'h03, 1'b1);
        push_byte(8'h10, 1'b0);
        push_byte(8'h20, 1'b0);
        push_byte(8'h30, 1'b0);
        push_byte(8'h40, 1'b0);
        push_byte(8'h50, 1'b1);
        drain();

        // Lower the setting to zero mid-line: the count runs on through 63 and wraps to zero
        write_groups(6'd8);
        push_stream(15, 1'b0);
        drain();
        write_groups(6'd0);
        push_stream(180 + $urandom_range(0, 8), 1'b1);
        drain();

        phase_groups[0] = 6'd2;
        phase_groups[1] = 6'd5;
        phase_groups[2] = 6'($urandom_range(1, 63));
        phase_groups[3] = 6'($urandom_range(1, 63));
        phase_groups[4] = GROUPS_RESET;
        for (int p = 0; p < 5; p++) begin
            write_groups(phase_groups[p]);
            phase_items = 0;
            while (phase_items < 35) begin
                len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 60)
                                                  : $urandom_range(1, 12);
                push_stream(len, 1'b1);
                phase_items += len;
            end
            drain();
        end

        repeat (20) @(posedge i_clk);
        if (mismatch_cnt == 0 && exp_chars.size() == 0)
            $display("base64_encoder_line_wrap_core test passed");
        else
            $display("base64_encoder_line_wrap_core test failed");
        $finish;
    end

endmodule
